>>> rtl/xor_fold_rotate_digest_unit_defines.svh
// ----------------------------------------------------------------------------
// xor fold rotate digest assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef XOR_FOLD_ROTATE_DIGEST_UNIT_DEFINES_SVH
`define XOR_FOLD_ROTATE_DIGEST_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define FRD_ASSERT_NEVER(lbl, cond, msg) \
  `FRD_ASSERT(lbl, !(cond), msg)
`else
`define FRD_ASSERT(lbl, prop, msg)
`define FRD_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/frd_pkg.sv
// ----------------------------------------------------------------------------
// frd_pkg
// shared constants, datapath command types and the lane rotate function
// ----------------------------------------------------------------------------
package frd_pkg;

  localparam int DIGEST_BYTES_DEF = 32;
  localparam int MIX_ROUNDS_DEF   = 3;

  localparam int MIX_DISTANCE = 7;
  localparam int ROT_LEFT     = 3;
  localparam int ROT_RIGHT    = 5;
  localparam int NIBBLE_SHIFT = 4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ABS_RD,
    OP_ABS_WR0,
    OP_ABS_WR1,
    OP_MIX_RD,
    OP_MIX_WR,
    OP_EMIT_RD,
    OP_CLEAR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_in;
  } dp_cmd_t;

  function automatic logic [7:0] rotl3(input logic [7:0] v);
    rotl3 = (v << ROT_LEFT) | (v >> ROT_RIGHT);
  endfunction

endpackage

>>> rtl/frd_datapath.sv
// ----------------------------------------------------------------------------
// frd_datapath
// lane memory with valid bits, absorb position, byte latch and mix logic
// ----------------------------------------------------------------------------
module frd_datapath import frd_pkg::*; #(
  parameter int DIGEST_BYTES = DIGEST_BYTES_DEF,
  localparam int IDX_W = $clog2(DIGEST_BYTES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  logic [IDX_W-1:0] lane_idx,
  input  logic [7:0]       in_data_byte,
  output logic [7:0]       out_digest_byte
);

  localparam logic [IDX_W-1:0] LAST_LANE = IDX_W'(DIGEST_BYTES - 1);
  localparam logic [IDX_W:0]   NB        = (IDX_W+1)'(DIGEST_BYTES);
  localparam logic [IDX_W:0]   DIST      = (IDX_W+1)'(MIX_DISTANCE);

  logic [7:0]             mem_r [DIGEST_BYTES];
  logic [DIGEST_BYTES-1:0] vld_r;
  logic [IDX_W-1:0]       pos_r;
  logic [7:0]             byte_r;
  logic [7:0]             rd0_r;
  logic [7:0]             rd1_r;

  logic [IDX_W-1:0] pos_inc;
  logic [IDX_W:0]   ahead_sum;
  logic [IDX_W-1:0] lane_ahead;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr0;
  logic [IDX_W-1:0] rd_addr1;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;

  assign pos_inc   = (pos_r == LAST_LANE) ? '0 : pos_r + 1'b1;
  assign ahead_sum = {1'b0, lane_idx} + DIST;
  // one compare and subtract, the sum stays below twice the lane count
  assign lane_ahead = (ahead_sum >= NB) ? IDX_W'(ahead_sum - NB) : IDX_W'(ahead_sum);

  always_comb begin
    rd_en    = 1'b0;
    rd_addr0 = lane_idx;
    rd_addr1 = lane_ahead;
    wr_en    = 1'b0;
    wr_addr  = lane_idx;
    wr_data  = rotl3(rd0_r ^ rd1_r);
    unique case (cmd.op)
      OP_ABS_RD: begin
        rd_en    = 1'b1;
        rd_addr0 = pos_r;
        rd_addr1 = pos_inc;
      end
      OP_ABS_WR0: begin
        wr_en   = 1'b1;
        wr_addr = pos_r;
        wr_data = rd0_r ^ byte_r;
      end
      OP_ABS_WR1: begin
        wr_en   = 1'b1;
        wr_addr = pos_inc;
        wr_data = rd1_r ^ (byte_r >> NIBBLE_SHIFT);
      end
      OP_MIX_RD: begin
        rd_en = 1'b1;
      end
      OP_MIX_WR: begin
        wr_en = 1'b1;
      end
      OP_EMIT_RD: begin
        rd_en = 1'b1;
      end
      OP_NONE, OP_CLEAR: begin
      end
      default: begin
      end
    endcase
  end

  // lane storage, entries without a valid bit read as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd0_r <= vld_r[rd_addr0] ? mem_r[rd_addr0] : 8'h00;
      rd1_r <= vld_r[rd_addr1] ? mem_r[rd_addr1] : 8'h00;
    end
    if (cmd.load_in) begin
      byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      pos_r <= '0;
    end else if (cmd.op == OP_CLEAR) begin
      vld_r <= '0;
      pos_r <= '0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (cmd.op == OP_ABS_WR1) begin
        pos_r <= pos_inc;
      end
    end
  end

  assign out_digest_byte = rd0_r;

endmodule

>>> rtl/frd_ctrl.sv
// ----------------------------------------------------------------------------
// frd_ctrl
// sequencer for absorb, mixing rounds and digest emission
// ----------------------------------------------------------------------------
`include "xor_fold_rotate_digest_unit_defines.svh"

module frd_ctrl import frd_pkg::*; #(
  parameter int DIGEST_BYTES = DIGEST_BYTES_DEF,
  parameter int MIX_ROUNDS   = MIX_ROUNDS_DEF,
  localparam int IDX_W = $clog2(DIGEST_BYTES)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_carries_byte,
  input  logic             in_end_of_message,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [4:0]       out_byte_position,
  output logic             out_final_byte,
  output dp_cmd_t          cmd,
  output logic [IDX_W-1:0] lane_idx
);

  localparam int RND_W = (MIX_ROUNDS > 1) ? $clog2(MIX_ROUNDS) : 1;
  localparam logic [IDX_W-1:0] LAST_LANE  = IDX_W'(DIGEST_BYTES - 1);
  localparam logic [RND_W-1:0] LAST_ROUND = RND_W'(MIX_ROUNDS - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ABS_RD,
    S_ABS_WR0,
    S_ABS_WR1,
    S_MIX_RD,
    S_MIX_WR,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] lane_r;
  logic [RND_W-1:0] round_r;
  logic             eom_r;
  logic             out_valid_r;

  logic in_fire;
  logic out_fire;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign out_valid = out_valid_r;
  assign lane_idx  = lane_r;
  assign out_byte_position = 5'(lane_r);
  assign out_final_byte    = (lane_r == LAST_LANE);

  always_comb begin
    cmd.load_in = in_fire;
    cmd.op      = OP_NONE;
    unique case (state_r)
      S_IDLE:      cmd.op = OP_NONE;
      S_ABS_RD:    cmd.op = OP_ABS_RD;
      S_ABS_WR0:   cmd.op = OP_ABS_WR0;
      S_ABS_WR1:   cmd.op = OP_ABS_WR1;
      S_MIX_RD:    cmd.op = OP_MIX_RD;
      S_MIX_WR:    cmd.op = OP_MIX_WR;
      S_EMIT_RD:   cmd.op = OP_EMIT_RD;
      S_EMIT_WAIT: cmd.op = (out_fire && lane_r == LAST_LANE) ? OP_CLEAR : OP_NONE;
      default:     cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lane_r      <= '0;
      round_r     <= '0;
      eom_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            eom_r <= in_end_of_message;
            if (in_carries_byte) begin
              state_r <= S_ABS_RD;
            end else if (in_end_of_message) begin
              state_r <= S_MIX_RD;
            end
          end
        end
        S_ABS_RD:  state_r <= S_ABS_WR0;
        S_ABS_WR0: state_r <= S_ABS_WR1;
        S_ABS_WR1: state_r <= eom_r ? S_MIX_RD : S_IDLE;
        S_MIX_RD:  state_r <= S_MIX_WR;
        S_MIX_WR: begin
          if (lane_r == LAST_LANE) begin
            lane_r <= '0;
            if (round_r == LAST_ROUND) begin
              round_r <= '0;
              state_r <= S_EMIT_RD;
            end else begin
              round_r <= round_r + 1'b1;
              state_r <= S_MIX_RD;
            end
          end else begin
            lane_r  <= lane_r + 1'b1;
            state_r <= S_MIX_RD;
          end
        end
        S_EMIT_RD: begin
          out_valid_r <= 1'b1;
          state_r     <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (lane_r == LAST_LANE) begin
              lane_r  <= '0;
              state_r <= S_IDLE;
            end else begin
              lane_r  <= lane_r + 1'b1;
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `FRD_ASSERT_NEVER(a_no_accept_while_emitting, in_ready && out_valid_r,
                    "input accepted while a digest item is pending")
  `FRD_ASSERT(a_final_done_returns_idle, out_fire && out_final_byte |=> in_ready,
              "block not idle after the last digest item")
  `FRD_ASSERT(a_round_in_range, round_r <= LAST_ROUND,
              "mixing round counter out of range")
  `FRD_ASSERT(a_valid_only_in_wait, out_valid_r |-> state_r == S_EMIT_WAIT,
              "result valid outside the emit wait state")

endmodule

>>> rtl/xor_fold_rotate_digest_unit.sv
// throughput: a byte item runs absorb read, write0, write1 before the next; an idle item every cycle
// end of message: MIX_ROUNDS mixing rounds over all DIGEST_BYTES lanes,
// one read and one write of the lane memory per mixing step
// then each digest item takes a memory read, then the output handshake
// reset clears lanes at once through per-lane valid bits; no clearing pass
// ----------------------------------------------------------------------------
// xor_fold_rotate_digest_unit
// byte-wise xor fold digest with rotate mixing rounds, top level
// ----------------------------------------------------------------------------
module xor_fold_rotate_digest_unit import frd_pkg::*; #(
  parameter int DIGEST_BYTES = DIGEST_BYTES_DEF,
  parameter int MIX_ROUNDS   = MIX_ROUNDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_carries_byte,
  input  logic       in_end_of_message,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_digest_byte,
  output logic [4:0] out_byte_position,
  output logic       out_final_byte
);

  localparam int IDX_W = $clog2(DIGEST_BYTES);

  dp_cmd_t          cmd;
  logic [IDX_W-1:0] lane_idx;

  frd_ctrl #(
    .DIGEST_BYTES(DIGEST_BYTES),
    .MIX_ROUNDS  (MIX_ROUNDS)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_carries_byte  (in_carries_byte),
    .in_end_of_message(in_end_of_message),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_position(out_byte_position),
    .out_final_byte   (out_final_byte),
    .cmd              (cmd),
    .lane_idx         (lane_idx)
  );

  frd_datapath #(
    .DIGEST_BYTES(DIGEST_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .lane_idx       (lane_idx),
    .in_data_byte   (in_data_byte),
    .out_digest_byte(out_digest_byte)
  );

endmodule

>>> bench/xor_fold_rotate_digest_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xor_fold_rotate_digest_unit_test
// drives message bytes through valid/ready in random bursts, folds each
// accepted item into a local lane model and checks every digest item
// against it while the receiver stalls at random, in patterns and in long hold-offs
// ----------------------------------------------------------------------------
module xor_fold_rotate_digest_unit_test;
  import frd_pkg::*;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 9;
  localparam int DIGEST_BYTES   = DIGEST_BYTES_DEF;
  localparam int MIX_ROUNDS     = MIX_ROUNDS_DEF;
  localparam int MESSAGE_ITEMS  = 260;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int HOLDOFF_FIRST  = 40;
  localparam int HOLDOFF_STRIDE = 350;
  localparam int HOLDOFF_COUNT  = 2;
  localparam int REPORT_LIMIT   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       carries;
    logic       eom;
  } msg_item_t;

  typedef struct packed {
    logic [7:0] value;
    logic [4:0] position;
    logic       is_last;
  } digest_item_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_t;

  logic       clk               = 1'b0;
  logic       rst_n             = 1'b0;
  logic       in_valid          = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte      = 8'h00;
  logic       in_carries_byte   = 1'b0;
  logic       in_end_of_message = 1'b0;
  logic       out_valid;
  logic       out_ready         = 1'b0;
  logic [7:0] out_digest_byte;
  logic [4:0] out_byte_position;
  logic       out_final_byte;

  msg_item_t    pending_q[$];
  digest_item_t digest_q[$];
  logic [7:0]   lanes[DIGEST_BYTES];
  int           fold_pos;

  int items_total;
  int items_accepted = 0;
  int results_seen   = 0;
  int mismatch_count = 0;
  int burst_left     = 0;
  int gap_left       = 0;
  int idle_cycles    = 0;

  rx_mode_t   rx_mode      = RX_ALWAYS;
  int         rx_phase     = 0;
  int         rx_pat_idx   = 0;
  logic [7:0] rx_pattern   = 8'hFF;
  int         hold_left    = 0;
  int         holdoffs_run = 0;

  xor_fold_rotate_digest_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_carries_byte   (in_carries_byte),
    .in_end_of_message (in_end_of_message),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_digest_byte   (out_digest_byte),
    .out_byte_position (out_byte_position),
    .out_final_byte    (out_final_byte)
  );

  always #CLK_HALF clk = ~clk;

  // fold one accepted item into the lanes, queue the digest on end of message
  function automatic void fold_item(msg_item_t it);
    logic [7:0] mixed;
    if (it.carries) begin
      lanes[fold_pos] ^= it.data;
      lanes[(fold_pos + 1) % DIGEST_BYTES] ^= it.data >> NIBBLE_SHIFT;
      fold_pos = (fold_pos + 1) % DIGEST_BYTES;
    end
    if (it.eom) begin
      // in-place rounds: lanes ahead may already hold this round's value
      for (int r = 0; r < MIX_ROUNDS; r++) begin
        for (int i = 0; i < DIGEST_BYTES; i++) begin
          mixed    = lanes[i] ^ lanes[(i + MIX_DISTANCE) % DIGEST_BYTES];
          lanes[i] = (mixed << ROT_LEFT) | (mixed >> ROT_RIGHT);
        end
      end
      for (int k = 0; k < DIGEST_BYTES; k++) begin
        digest_q.push_back('{value: lanes[k], position: 5'(k),
                             is_last: (k == DIGEST_BYTES - 1)});
        lanes[k] = 8'h00;
      end
      fold_pos = 0;
    end
  endfunction

  function automatic void add_item(logic [7:0] data, logic carries, logic eom);
    pending_q.push_back('{data: data, carries: carries, eom: eom});
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       pick_byte = 8'h00;
      1:       pick_byte = 8'hFF;
      default: pick_byte = 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void build_stimulus();
    int counted;
    int len;
    int msg_idx;
    // empty message, then an ignored idle item
    add_item(8'h00, 1'b0, 1'b1);
    add_item(8'hFF, 1'b0, 1'b0);
    // single byte carried on the final item
    add_item(8'hFF, 1'b1, 1'b1);
    add_item(8'h00, 1'b1, 1'b1);
    // end of message without a byte after absorbed bytes
    add_item(8'h80, 1'b1, 1'b0);
    add_item(8'h01, 1'b1, 1'b0);
    add_item(8'h5A, 1'b0, 1'b0);
    add_item(8'hC3, 1'b0, 1'b1);
    add_item(8'hF0, 1'b1, 1'b0);
    add_item(8'h0F, 1'b1, 1'b0);
    add_item(8'hA5, 1'b1, 1'b1);
    // empty message again, ignored byte set
    add_item(8'hFF, 1'b0, 1'b1);

    counted = 0;
    msg_idx = 0;
    while (counted < MESSAGE_ITEMS) begin
      if ($urandom_range(0, 15) == 0) begin
        add_item(pick_byte(), 1'b0, 1'b1);
        counted++;
      end else begin
        // long messages wrap the fold position onto earlier lanes
        if (msg_idx == 0 || $urandom_range(0, 6) == 0)
          len = $urandom_range(33, 72);
        else
          len = $urandom_range(1, 12);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 7) == 0) begin
            add_item(pick_byte(), 1'b0, 1'b0);
            counted++;
          end
          add_item(pick_byte(), 1'b1, 1'b0);
          counted++;
        end
        add_item(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
        counted++;
      end
      msg_idx++;
    end
    // close with an empty message so nothing is left half folded
    add_item(8'h00, 1'b0, 1'b1);
  endfunction

  // sender: bursts of items with random gaps
  always @(posedge clk) begin : drive_items
    logic      offer;
    msg_item_t next_item;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        fold_item('{data: in_data_byte, carries: in_carries_byte,
                    eom: in_end_of_message});
        items_accepted <= items_accepted + 1;
        offer = 1'b0;
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_q.size() > 0) begin
          next_item = pending_q.pop_front();
          in_data_byte      <= next_item.data;
          in_carries_byte   <= next_item.carries;
          in_end_of_message <= next_item.eom;
          offer = 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
      in_valid <= offer;
    end
  end

  // receiver: stall modes that change every phase, plus long hold-offs
  always @(posedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holdoffs_run < HOLDOFF_COUNT &&
                 results_seen >= HOLDOFF_FIRST + holdoffs_run * HOLDOFF_STRIDE) begin
      hold_left    <= HOLDOFF_CYCLES;
      holdoffs_run <= holdoffs_run + 1;
      out_ready    <= 1'b0;
    end else begin
      if (rx_phase == 0) begin
        rx_mode    <= rx_mode_t'($urandom_range(0, 2));
        rx_pattern <= 8'($urandom_range(1, 255));
        rx_phase   <= $urandom_range(20, 120);
      end else begin
        rx_phase <= rx_phase - 1;
      end
      rx_pat_idx <= (rx_pat_idx + 1) % 8;
      case (rx_mode)
        RX_ALWAYS:  out_ready <= 1'b1;
        RX_RANDOM:  out_ready <= 1'($urandom_range(0, 1));
        RX_PATTERN: out_ready <= rx_pattern[rx_pat_idx];
        default:    out_ready <= 1'b1;
      endcase
    end
  end

  function automatic void flag_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t mismatch: %s", $realtime, what);
  endfunction

  always @(posedge clk) begin : check_digest
    digest_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (digest_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected item byte=%02h pos=%0d last=%0b",
                                out_digest_byte, out_byte_position, out_final_byte));
      end else begin
        want = digest_q.pop_front();
        if (out_digest_byte !== want.value || out_byte_position !== want.position ||
            out_final_byte !== want.is_last)
          flag_mismatch($sformatf("byte exp=%02h got=%02h pos exp=%0d got=%0d last exp=%0b got=%0b",
                                  want.value, out_digest_byte, want.position,
                                  out_byte_position, want.is_last, out_final_byte));
      end
    end
  end

  // nothing accepted on either channel for too long
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[xor_fold_rotate_digest_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < DIGEST_BYTES; i++)
      lanes[i] = 8'h00;
    fold_pos = 0;
    build_stimulus();
    items_total = pending_q.size();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    while (items_accepted < items_total) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatch_count += digest_q.size();
    if (mismatch_count == 0) begin
      $display("[xor_fold_rotate_digest_unit] OK");
    end else begin
      $display("[xor_fold_rotate_digest_unit] ERROR");
    end
    $finish;
  end

endmodule
